// File: rtl/core/tksf_pkg.sv
// ---------------------------------------------------------------------------
// tksf_pkg
// Shared types, opcodes and microprogram for the two-state Kalman step core.
// ---------------------------------------------------------------------------
package tksf_pkg;

	// register-file addresses
	typedef enum logic [4:0] {
		R_ZERO, R_ONE, R_P00, R_P01, R_P10, R_P11, R_X0, R_X1,
		R_F00, R_F01, R_F10, R_F11, R_H0, R_H1, R_G0, R_G1,
		R_Q, R_R, R_Z, R_U, R_DT, R_T0, R_T1, R_T2,
		R_T3, R_M00, R_M01, R_M10, R_M11, R_K0, R_K1, R_T4
	} reg_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		IDX_PHI00, IDX_PHI01, IDX_PHI10, IDX_PHI11,
		IDX_OBSERVE, IDX_CONTROL, IDX_QNOISE, IDX_RNOISE
	} cfg_idx_t;

	typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_WAIT, S_DIV, S_OUT} st_t;

	typedef enum logic [2:0] {
		OP_MUL, OP_MAC, OP_ADD, OP_SUB, OP_DIV, OP_THIRD, OP_HALF, OP_END
	} op_t;

	// MUL:  d = a*b      MAC: d = acc + a*b  (acc = previous result)
	// ADD:  d = a+b      SUB: d = a-b
	// DIV:  d = a/b (b = innovation variance, fault path zeroes gain)
	typedef struct packed {
		op_t  op;
		reg_t a;
		reg_t b;
		reg_t d;
	} uword_t;

	localparam int SB = 6;

	function automatic uword_t uw(op_t o, reg_t a, reg_t b, reg_t d);
		uword_t w;
		w.op = o; w.a = a; w.b = b; w.d = d;
		return w;
	endfunction

	function automatic uword_t prog(logic [SB-1:0] pc);
		uword_t w;
		w = uw(OP_END, R_ZERO, R_ZERO, R_ZERO);
		case (pc)
			// dt2 -> T4, dt3 -> T0, Qk pieces
			6'd0:  w = uw(OP_MUL, R_DT, R_DT, R_T4);
			6'd1:  w = uw(OP_MUL, R_T4, R_DT, R_T0);
			6'd2:  w = uw(OP_THIRD, R_T0, R_ZERO, R_T0);
			6'd3:  w = uw(OP_MUL, R_T0, R_Q, R_M00);
			6'd4:  w = uw(OP_HALF, R_T4, R_ZERO, R_T4);
			6'd5:  w = uw(OP_MUL, R_T4, R_Q, R_M01);
			6'd6:  w = uw(OP_MUL, R_DT, R_Q, R_M11);
			// T = Phi P
			6'd7:  w = uw(OP_MUL, R_F00, R_P00, R_T0);
			6'd8:  w = uw(OP_MAC, R_F01, R_P10, R_T0);
			6'd9:  w = uw(OP_MUL, R_F00, R_P01, R_T1);
			6'd10: w = uw(OP_MAC, R_F01, R_P11, R_T1);
			6'd11: w = uw(OP_MUL, R_F10, R_P00, R_T2);
			6'd12: w = uw(OP_MAC, R_F11, R_P10, R_T2);
			6'd13: w = uw(OP_MUL, R_F10, R_P01, R_T3);
			6'd14: w = uw(OP_MAC, R_F11, R_P11, R_T3);
			// M = T Phi' + Qk  (P regs reused as scratch)
			6'd15: w = uw(OP_MUL, R_T0, R_F00, R_P00);
			6'd16: w = uw(OP_MAC, R_T1, R_F01, R_P00);
			6'd17: w = uw(OP_ADD, R_P00, R_M00, R_M00);
			6'd18: w = uw(OP_MUL, R_T0, R_F10, R_P00);
			6'd19: w = uw(OP_MAC, R_T1, R_F11, R_P00);
			6'd20: w = uw(OP_MUL, R_T2, R_F00, R_P01);
			6'd21: w = uw(OP_MAC, R_T3, R_F01, R_P01);
			6'd22: w = uw(OP_ADD, R_P01, R_M01, R_M10);
			6'd23: w = uw(OP_ADD, R_P00, R_M01, R_M01);
			6'd24: w = uw(OP_MUL, R_T2, R_F10, R_P00);
			6'd25: w = uw(OP_MAC, R_T3, R_F11, R_P00);
			6'd26: w = uw(OP_ADD, R_P00, R_M11, R_M11);
			// HM -> T0,T1 ; s -> T2 ; MH -> P00,P01
			6'd27: w = uw(OP_MUL, R_H0, R_M00, R_T0);
			6'd28: w = uw(OP_MAC, R_H1, R_M10, R_T0);
			6'd29: w = uw(OP_MUL, R_H0, R_M01, R_T1);
			6'd30: w = uw(OP_MAC, R_H1, R_M11, R_T1);
			6'd31: w = uw(OP_MUL, R_T0, R_H0, R_T2);
			6'd32: w = uw(OP_MAC, R_T1, R_H1, R_T2);
			6'd33: w = uw(OP_ADD, R_T2, R_R, R_T2);
			6'd34: w = uw(OP_MUL, R_M00, R_H0, R_P00);
			6'd35: w = uw(OP_MAC, R_M01, R_H1, R_P00);
			6'd36: w = uw(OP_MUL, R_M10, R_H0, R_P01);
			6'd37: w = uw(OP_MAC, R_M11, R_H1, R_P01);
			6'd38: w = uw(OP_DIV, R_P00, R_T2, R_K0);
			6'd39: w = uw(OP_DIV, R_P01, R_T2, R_K1);
			// A = I - K H  -> T0..T3
			6'd40: w = uw(OP_MUL, R_K0, R_H0, R_T0);
			6'd41: w = uw(OP_SUB, R_ONE, R_T0, R_T0);
			6'd42: w = uw(OP_MUL, R_K0, R_H1, R_T1);
			6'd43: w = uw(OP_SUB, R_ZERO, R_T1, R_T1);
			6'd44: w = uw(OP_MUL, R_K1, R_H0, R_T2);
			6'd45: w = uw(OP_SUB, R_ZERO, R_T2, R_T2);
			6'd46: w = uw(OP_MUL, R_K1, R_H1, R_T3);
			6'd47: w = uw(OP_SUB, R_ONE, R_T3, R_T3);
			// P = A M
			6'd48: w = uw(OP_MUL, R_T0, R_M00, R_P00);
			6'd49: w = uw(OP_MAC, R_T1, R_M10, R_P00);
			6'd50: w = uw(OP_MUL, R_T0, R_M01, R_P01);
			6'd51: w = uw(OP_MAC, R_T1, R_M11, R_P01);
			6'd52: w = uw(OP_MUL, R_T2, R_M00, R_P10);
			6'd53: w = uw(OP_MAC, R_T3, R_M10, R_P10);
			6'd54: w = uw(OP_MUL, R_T2, R_M01, R_P11);
			6'd55: w = uw(OP_MAC, R_T3, R_M11, R_P11);
			// Phi x -> T0,T1 ; G u -> T2,T3 (summed into xp in phase 2)
			6'd56: w = uw(OP_MUL, R_F00, R_X0, R_T0);
			6'd57: w = uw(OP_MAC, R_F01, R_X1, R_T0);
			6'd58: w = uw(OP_MUL, R_F10, R_X0, R_T1);
			6'd59: w = uw(OP_MAC, R_F11, R_X1, R_T1);
			6'd60: w = uw(OP_MUL, R_G0, R_U, R_T2);
			6'd61: w = uw(OP_MUL, R_G1, R_U, R_T3);
			// continuation at phase 2 (pc restarts at zero with the page bit set)
			default: w = uw(OP_END, R_ZERO, R_ZERO, R_ZERO);
		endcase
		return w;
	endfunction

	function automatic uword_t prog2(logic [SB-1:0] pc);
		uword_t w;
		w = uw(OP_END, R_ZERO, R_ZERO, R_ZERO);
		case (pc)
			6'd0:  w = uw(OP_MUL, R_H0, R_T0, R_M00);
			6'd1:  w = uw(OP_MAC, R_H1, R_T1, R_M00);
			6'd2:  w = uw(OP_SUB, R_Z, R_M00, R_M00);
			6'd3:  w = uw(OP_MUL, R_H0, R_T2, R_M01);
			6'd4:  w = uw(OP_MAC, R_H1, R_T3, R_M01);
			6'd5:  w = uw(OP_SUB, R_M00, R_M01, R_M00);
			6'd6:  w = uw(OP_ADD, R_T0, R_T2, R_T0);
			6'd7:  w = uw(OP_ADD, R_T1, R_T3, R_T1);
			6'd8:  w = uw(OP_MUL, R_K0, R_M00, R_T2);
			6'd9:  w = uw(OP_ADD, R_T0, R_T2, R_X0);
			6'd10: w = uw(OP_MUL, R_K1, R_M00, R_T3);
			6'd11: w = uw(OP_ADD, R_T1, R_T3, R_X1);
			default: w = uw(OP_END, R_ZERO, R_ZERO, R_ZERO);
		endcase
		return w;
	endfunction

endpackage

// File: rtl/core/two_state_kalman_filter_step_core.sv
// Work per item: 55 multiply steps on the shared multiplier, 17 ALU steps, two
// page ends, one output step and two divisions (a gain fault skips both
// divisions). One item at a time: next input taken the cycle after the
// result transfer. Reset (arst_n low): registers, estimate and covariance
// cleared to zero, except the constant-one register.
// ---------------------------------------------------------------------------
// two_state_kalman_filter_step_core
// Microcoded two-state Kalman step: ROM program over a shared fixed-point ALU.
// ---------------------------------------------------------------------------
module two_state_kalman_filter_step_core #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // measurement, control_in, time_step
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // est_position, est_rate, gain_first, gain_second
	output logic         m_tuser,   // gain_fault
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	import tksf_pkg::*;

	localparam logic signed [63:0] WMAX = (64'sd1 <<< (WORD_BITS - 1)) - 1;

	logic signed [WORD_BITS-1:0] rf_q [32];
	st_t st_q, st_d;
	logic [SB-1:0] pc_q;
	logic page_q;
	uword_t cw;
	logic signed [WORD_BITS-1:0] opa, opb, res, acc_q, quo;
	logic div_start, div_done, fault_q;

	function automatic logic signed [WORD_BITS-1:0] ld(logic signed [63:0] v);
		return WORD_BITS'(v > WMAX ? WMAX : (v < -WMAX - 1 ? -WMAX - 1 : v));
	endfunction

	assign cw  = page_q ? prog2(pc_q) : prog(pc_q);
	assign opa = rf_q[cw.a];
	assign opb = rf_q[cw.b];
	assign s_tready  = (st_q == S_IDLE) && !m_tvalid;
	// registers change only between items
	assign cfg_ready = (st_q == S_IDLE);
	assign div_start = (st_q == S_ISSUE) && (cw.op == OP_DIV) && (opb > 0);

	tksf_alu #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_alu (
		.clk(clk), .op(cw.op), .a(opa), .b(opb), .acc(acc_q), .res(res));

	tksf_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(opa), .den(opb),
		.done(div_done), .quo(quo));

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_IDLE:  if (s_tvalid && s_tready) st_d = S_ISSUE;
			S_ISSUE: begin
				if (cw.op == OP_END) st_d = page_q ? S_OUT : S_ISSUE;
				else if (div_start) st_d = S_DIV;
				else if (cw.op == OP_MUL || cw.op == OP_MAC) st_d = S_WAIT;
			end
			S_WAIT:  st_d = S_ISSUE;
			S_DIV:   if (div_done) st_d = S_ISSUE;
			S_OUT:   st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			pc_q <= '0;
			page_q <= 1'b0;
			m_tvalid <= 1'b0;
			fault_q <= 1'b0;
			acc_q <= '0;
			for (int i = 0; i < 32; i++)
				rf_q[i] <= (i == R_ONE) ? ld(64'sd1 <<< FRAC_BITS) : '0;
		end else begin
			st_q <= st_d;
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					IDX_PHI00: rf_q[R_F00] <= ld(64'($signed(cfg_data[31:0])));
					IDX_PHI01: rf_q[R_F01] <= ld(64'($signed(cfg_data[31:0])));
					IDX_PHI10: rf_q[R_F10] <= ld(64'($signed(cfg_data[31:0])));
					IDX_PHI11: rf_q[R_F11] <= ld(64'($signed(cfg_data[31:0])));
					IDX_OBSERVE: begin
						rf_q[R_H0] <= ld(64'($signed(cfg_data[31:0])));
						rf_q[R_H1] <= ld(64'($signed(cfg_data[63:32])));
					end
					IDX_CONTROL: begin
						rf_q[R_G0] <= ld(64'($signed(cfg_data[31:0])));
						rf_q[R_G1] <= ld(64'($signed(cfg_data[63:32])));
					end
					IDX_QNOISE: rf_q[R_Q] <= ld(64'({1'b0, cfg_data[30:0]}));
					IDX_RNOISE: rf_q[R_R] <= ld(64'({1'b0, cfg_data[30:0]}));
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					rf_q[R_Z]  <= ld(64'($signed(s_tdata[31:0])));
					rf_q[R_U]  <= ld(64'($signed(s_tdata[63:32])));
					rf_q[R_DT] <= ld(64'({1'b0, s_tdata[87:64]}));
					pc_q <= '0;
					page_q <= 1'b0;
					fault_q <= 1'b0;
				end
				S_ISSUE: begin
					if (cw.op == OP_END) begin
						pc_q <= '0;
						page_q <= 1'b1;
					end else if (cw.op == OP_DIV) begin
						if (!div_start) begin
							rf_q[cw.d] <= '0;
							fault_q <= 1'b1;
							pc_q <= pc_q + 1'b1;
						end
					end else if (cw.op != OP_MUL && cw.op != OP_MAC) begin
						rf_q[cw.d] <= res;
						pc_q <= pc_q + 1'b1;
					end
				end
				S_WAIT: begin
					rf_q[cw.d] <= res;
					acc_q <= res;
					pc_q <= pc_q + 1'b1;
				end
				S_DIV: if (div_done) begin
					rf_q[cw.d] <= quo;
					pc_q <= pc_q + 1'b1;
				end
				S_OUT: begin
					m_tvalid <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign m_tdata = {32'(rf_q[R_K1]), 32'(rf_q[R_K0]), 32'(rf_q[R_X1]), 32'(rf_q[R_X0])};
	assign m_tuser = fault_q;
endmodule

// File: rtl/core/tksf_div.sv
// ---------------------------------------------------------------------------
// tksf_div
// Restoring divider, one quotient bit per cycle, round to nearest, saturate.
// ---------------------------------------------------------------------------
module tksf_div #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [WORD_BITS-1:0] num,
	input  logic signed [WORD_BITS-1:0] den,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] quo
);
	localparam int NB = WORD_BITS + FRAC_BITS;
	localparam int CB = $clog2(NB + 1);

	logic [NB-1:0]      n_q;
	logic [WORD_BITS:0] r_q;
	logic [WORD_BITS:0] d_q;
	logic [NB:0]        q_q;
	logic               neg_q;
	logic               busy_q;
	logic [CB-1:0]      cnt_q;
	logic [WORD_BITS+1:0] rs;
	logic               ge;
	logic [NB:0]        qr;
	logic [WORD_BITS:0] lim;
	logic [NB:0]        qmag;

	assign rs = {r_q, n_q[NB-1]};
	assign ge = rs >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CB'(NB - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[WORD_BITS-1];
			n_q   <= {(num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num)),
				{FRAC_BITS{1'b0}}};
			if (num == {1'b1, {(WORD_BITS-1){1'b0}}})
				n_q <= {1'b1, {(NB-1){1'b0}}};
			r_q   <= '0;
			q_q   <= '0;
			d_q   <= {1'b0, den};
		end else if (busy_q) begin
			n_q <= n_q << 1;
			r_q <= ge ? (WORD_BITS+1)'(rs - {1'b0, d_q}) : rs[WORD_BITS:0];
			q_q <= {q_q[NB-1:0], ge};
		end
	end

	// final rounding: remainder >= d - remainder
	always_comb begin
		qr = q_q + ((r_q >= (d_q - r_q)) ? (NB+1)'(1) : '0);
		qmag = qr;
		lim = neg_q ? {1'b0, 1'b1, {(WORD_BITS-1){1'b0}}}
			: {2'b00, {(WORD_BITS-1){1'b1}}};
		if (qmag > (NB+1)'(lim)) qmag = (NB+1)'(lim);
		quo = neg_q ? WORD_BITS'(-qmag) : WORD_BITS'(qmag);
	end
endmodule

// File: rtl/core/tksf_alu.sv
// ---------------------------------------------------------------------------
// tksf_alu
// Shared fixed-point datapath: registered multiply, add/sub, halve, divide by three, saturation.
// ---------------------------------------------------------------------------
module tksf_alu #(
	parameter int WORD_BITS = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  tksf_pkg::op_t               op,
	input  logic signed [WORD_BITS-1:0] a,
	input  logic signed [WORD_BITS-1:0] b,
	input  logic signed [WORD_BITS-1:0] acc,
	output logic signed [WORD_BITS-1:0] res
);
	import tksf_pkg::*;

	localparam int PW = 2 * WORD_BITS + 2;
	localparam logic signed [PW-1:0] MAXV = PW'((64'sd1 <<< (WORD_BITS - 1)) - 1);
	localparam logic signed [PW-1:0] MINV = -MAXV - 1;
	// divide by three as multiply by reciprocal; odd shift keeps it exact
	// for operands below 2^WORD_BITS
	localparam int TK = (WORD_BITS % 2 == 1) ? WORD_BITS : WORD_BITS + 1;
	localparam logic [63:0] TM = ((64'd1 << TK) + 64'd1) / 64'd3;

	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] prod;
	logic        [PW-1:0] pm;
	logic        [PW-1:0] pr;
	logic signed [PW-1:0] mres;
	logic signed [PW-1:0] sum;
	logic signed [PW-1:0] aw, bw, cw;
	logic        [PW-1:0] tx;
	logic        [PW-1:0] tp;

	// product register: one multiply per cycle, rounded on next cycle
	always_ff @(posedge clk) prod_s1 <= PW'(a) * PW'(b);

	function automatic logic signed [PW-1:0] satw(logic signed [PW-1:0] v);
		return v > MAXV ? MAXV : (v < MINV ? MINV : v);
	endfunction

	always_comb begin
		prod = prod_s1;
		pm   = prod[PW-1] ? PW'(-prod) : PW'(prod);
		pr   = (pm + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		mres = satw(prod[PW-1] ? -$signed(pr) : $signed(pr));
		aw = PW'(a);
		bw = PW'(b);
		cw = PW'(acc);
		// operand of THIRD is nonnegative
		tx = PW'(aw + PW'(1));
		tp = tx * PW'(TM);
		case (op)
			OP_MUL:  sum = mres;
			OP_MAC:  sum = satw(cw + mres);
			OP_ADD:  sum = satw(aw + bw);
			OP_SUB:  sum = satw(aw - bw);
			OP_THIRD: sum = PW'(tp >> TK);
			OP_HALF: sum = (aw + PW'(1)) >>> 1;
			default: sum = '0;
		endcase
		res = WORD_BITS'(sum);
	end
endmodule

// File: rtl/core/tksf_checker.sv
// ---------------------------------------------------------------------------
// tksf_checker
// Port-level checks for the Kalman step core.
// ---------------------------------------------------------------------------
module tksf_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic m_tuser,
	input logic [127:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken during work");
	a_noin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input open while result pending");
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[127:64] == '0)
		else $error("gain nonzero on fault");
endmodule

bind two_state_kalman_filter_step_core tksf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata));
